>>> src/multiply_shift_hash_collision_test_unit_defines.svh
// Assertion macros for the multiply-shift hash collision test unit.
`ifndef MULTIPLY_SHIFT_HASH_COLLISION_TEST_UNIT_DEFINES_SVH
`define MULTIPLY_SHIFT_HASH_COLLISION_TEST_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define MSHCT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mshct assertion failed");
`define MSHCT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mshct assertion failed");
`else
`define MSHCT_ASSERT(lbl, clk, rst, prop)
`define MSHCT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> src/mshct_pkg.sv
// Shared types and constants of the multiply-shift hash collision test unit.
package mshct_pkg;

   localparam int DEF_MAX_INDEX_BITS = 12;
   localparam int WORD_W             = 64;
   localparam int HALF_W             = WORD_W / 2;
   localparam int IDXCFG_W           = 4;
   localparam int COLL_W             = 16;
   localparam int FILL_W             = 13;
   localparam int CSR_IDX_W          = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_MULTIPLIER = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS = 1'd1;

   localparam logic [IDXCFG_W-1:0] INDEX_BITS_RST = 4'd12;

   typedef struct packed {
      logic [WORD_W-1:0] board_word;
      logic              last_board;
      logic              restart_search;
   } req_type;

   typedef struct packed {
      logic [COLL_W-1:0] collision_count;
      logic [FILL_W-1:0] fill_total;
      logic              new_best;
      logic [WORD_W-1:0] best_multiplier;
      logic [COLL_W-1:0] best_collisions;
      logic [FILL_W-1:0] best_filled;
      logic              perfect_found;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_UPDATE,
      ST_REPORT,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic restart;
      logic update;
      logic collision;
      logic fill;
      logic report;
   } track_ctl_type;

endpackage

>>> src/mshct_hash.sv
// Two-stage multiply-shift hash: partial products, then high-word sum and index shift.
module mshct_hash #(
   parameter int MAX_INDEX_BITS = mshct_pkg::DEF_MAX_INDEX_BITS
) (
   input  logic                                         clock,
   input  logic [mshct_pkg::WORD_W-1:0]                 board,
   input  logic [mshct_pkg::WORD_W-1:0]                 multiplier,
   input  logic [$clog2(MAX_INDEX_BITS+1)-1:0]          eff_bits,
   output logic [MAX_INDEX_BITS-1:0]                    index
);
   import mshct_pkg::*;

   localparam int BITS_W = $clog2(MAX_INDEX_BITS + 1);

   logic [WORD_W-1:0] p_ll_ff;
   logic [HALF_W-1:0] p_lh_ff;
   logic [HALF_W-1:0] p_hl_ff;
   logic [HALF_W-1:0] high_word;
   logic [MAX_INDEX_BITS-1:0] top_bits;
   logic [BITS_W-1:0] shift_amt;

   always_ff @(posedge clock) begin
      p_ll_ff <= board[HALF_W-1:0] * multiplier[HALF_W-1:0];
      p_lh_ff <= HALF_W'(board[HALF_W-1:0] * multiplier[WORD_W-1:HALF_W]);
      p_hl_ff <= HALF_W'(board[WORD_W-1:HALF_W] * multiplier[HALF_W-1:0]);
   end

   always_comb begin
      high_word = p_ll_ff[WORD_W-1:HALF_W] + p_lh_ff + p_hl_ff;
      top_bits  = high_word[HALF_W-1 -: MAX_INDEX_BITS];
      shift_amt = BITS_W'(MAX_INDEX_BITS) - eff_bits;
      index     = top_bits >> shift_amt;
   end

endmodule

>>> src/mshct_table.sv
// Hash table memory with fill marks and the sweep that clears it.
module mshct_table #(
   parameter int MAX_INDEX_BITS = mshct_pkg::DEF_MAX_INDEX_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear_go,
   input  logic                             rd_en,
   input  logic [MAX_INDEX_BITS-1:0]        rd_addr,
   output logic [mshct_pkg::WORD_W:0]       rd_data,
   input  logic                             wr_en,
   input  logic [MAX_INDEX_BITS-1:0]        wr_addr,
   input  logic [mshct_pkg::WORD_W:0]       wr_data,
   output logic                             clear_active,
   output logic                             clear_last
);
   import mshct_pkg::*;

   localparam int DEPTH = 1 << MAX_INDEX_BITS;

   logic [WORD_W:0]           mem_ff [DEPTH];
   logic [WORD_W:0]           rd_data_ff;
   logic                      clear_active_ff;
   logic                      clear_active_in;
   logic [MAX_INDEX_BITS-1:0] clear_addr_ff;
   logic [MAX_INDEX_BITS-1:0] clear_addr_in;

   always_ff @(posedge clock) begin
      if (clear_active_ff) begin
         mem_ff[clear_addr_ff] <= '0;
      end else if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_comb begin
      clear_last      = clear_active_ff && (&clear_addr_ff);
      clear_active_in = clear_active_ff && !clear_last;
      clear_addr_in   = clear_active_ff ? clear_addr_ff + 1'b1 : clear_addr_ff;
      if (clear_go) begin
         clear_active_in = 1'b1;
         clear_addr_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
      end else begin
         clear_active_ff <= clear_active_in;
         clear_addr_ff   <= clear_addr_in;
      end
   end

   assign rd_data      = rd_data_ff;
   assign clear_active = clear_active_ff;

endmodule

>>> src/mshct_track.sv
// Trial counters, best-so-far tracking and the result register.
module mshct_track (
   input  logic                             clock,
   input  logic                             reset,
   input  mshct_pkg::track_ctl_type         ctl,
   input  logic [mshct_pkg::WORD_W-1:0]     multiplier,
   output logic                             rsp_valid,
   output mshct_pkg::rsp_type               rsp_item
);
   import mshct_pkg::*;

   logic [COLL_W-1:0] trial_coll_ff;
   logic [FILL_W-1:0] trial_fill_ff;
   logic [WORD_W-1:0] best_word_ff;
   logic [COLL_W-1:0] best_coll_ff;
   logic [FILL_W-1:0] best_fill_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              better;
   logic [WORD_W-1:0] best_word_in;
   logic [COLL_W-1:0] best_coll_in;
   logic [FILL_W-1:0] best_fill_in;
   rsp_type           rsp_in;

   always_comb begin
      better = (trial_coll_ff < best_coll_ff) ||
               ((trial_coll_ff == best_coll_ff) && (trial_fill_ff > best_fill_ff));
      best_word_in = better ? multiplier    : best_word_ff;
      best_coll_in = better ? trial_coll_ff : best_coll_ff;
      best_fill_in = better ? trial_fill_ff : best_fill_ff;
      rsp_in.collision_count = trial_coll_ff;
      rsp_in.fill_total      = trial_fill_ff;
      rsp_in.new_best        = better;
      rsp_in.best_multiplier = best_word_in;
      rsp_in.best_collisions = best_coll_in;
      rsp_in.best_filled     = best_fill_in;
      rsp_in.perfect_found   = (best_coll_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trial_coll_ff <= '0;
         trial_fill_ff <= '0;
         best_word_ff  <= '0;
         best_coll_ff  <= '1;
         best_fill_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.report;
         if (ctl.update) begin
            if (ctl.collision && !(&trial_coll_ff)) begin
               trial_coll_ff <= trial_coll_ff + 1'b1;
            end
            if (ctl.fill && !(&trial_fill_ff)) begin
               trial_fill_ff <= trial_fill_ff + 1'b1;
            end
         end
         if (ctl.report) begin
            trial_coll_ff <= '0;
            trial_fill_ff <= '0;
            best_word_ff  <= best_word_in;
            best_coll_ff  <= best_coll_in;
            best_fill_ff  <= best_fill_in;
         end
         if (ctl.restart) begin
            best_word_ff <= '0;
            best_coll_ff <= '1;
            best_fill_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.report) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> src/multiply_shift_hash_collision_test_unit.sv
// Top level of the multiply-shift hash collision test unit: control, config, wiring.
//
// Usage:
//  - Write the multiplier (index 0) and index_bits (index 1) through csr_we,
//    csr_index and csr_wdata while busy is low; writes take effect at once.
//  - Present a board item on req_item with start high; it is taken at the
//    clock edge where start is high and busy is low.
//  - Each board passes through accept, multiply partial products, sum and
//    table read, then table write-back and counter update. The two hash
//    stages and the read-modify-write of the hash table memory set these steps.
//  - A board flagged last_board adds a report state; rsp_valid pulses for one
//    cycle, registered from the report state, with the trial's results.
//  - After each last board the table is swept clear, one entry per cycle,
//    all 2**MAX_INDEX_BITS entries (4096 by default), with busy held high.
//  - Reset is synchronous; it clears control and best-so-far state and starts
//    the same clearing sweep, so busy stays high until the sweep is done.
//  - Results cannot be held off: rsp_item is valid only while rsp_valid is high.
module multiply_shift_hash_collision_test_unit #(
   parameter int MAX_INDEX_BITS = mshct_pkg::DEF_MAX_INDEX_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  mshct_pkg::req_type                   req_item,
   input  logic                                 csr_we,
   input  logic [mshct_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mshct_pkg::WORD_W-1:0]         csr_wdata,
   output logic                                 rsp_valid,
   output mshct_pkg::rsp_type                   rsp_item
);
   import mshct_pkg::*;

`include "multiply_shift_hash_collision_test_unit_defines.svh"

   localparam int BITS_W = $clog2(MAX_INDEX_BITS + 1);

   state_type                 state_ff;
   state_type                 state_in;
   req_type                   req_ff;
   logic [WORD_W-1:0]         csr_multiplier_ff;
   logic [IDXCFG_W-1:0]       csr_index_bits_ff;
   logic [BITS_W-1:0]         eff_bits;
   logic [MAX_INDEX_BITS-1:0] hash_index;
   logic [MAX_INDEX_BITS-1:0] index_ff;
   logic                      accept;
   logic                      rd_en;
   logic                      wr_en;
   logic                      clear_go;
   logic                      clear_active;
   logic                      clear_last;
   logic [WORD_W:0]           rd_data;
   logic [WORD_W:0]           wr_data;
   logic                      entry_empty;
   track_ctl_type             track_ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_multiplier_ff <= '0;
         csr_index_bits_ff <= INDEX_BITS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MULTIPLIER: csr_multiplier_ff <= csr_wdata;
            CSR_INDEX_BITS: csr_index_bits_ff <= csr_wdata[IDXCFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (csr_index_bits_ff == '0) begin
         eff_bits = BITS_W'(1);
      end else if (int'(csr_index_bits_ff) > MAX_INDEX_BITS) begin
         eff_bits = BITS_W'(MAX_INDEX_BITS);
      end else begin
         eff_bits = BITS_W'(csr_index_bits_ff);
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      if (state_ff == ST_SUM) begin
         index_ff <= hash_index;
      end
   end

   always_comb begin
      entry_empty = (rd_data[WORD_W-1:0] == '0);
      wr_data     = {1'b1, entry_empty ? req_ff.board_word : rd_data[WORD_W-1:0]};

      state_in            = state_ff;
      rd_en               = 1'b0;
      wr_en               = 1'b0;
      clear_go            = 1'b0;
      track_ctl.restart   = accept && req_item.restart_search;
      track_ctl.update    = 1'b0;
      track_ctl.collision = !entry_empty && (rd_data[WORD_W-1:0] != req_ff.board_word);
      track_ctl.fill      = !rd_data[WORD_W];
      track_ctl.report    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rd_en    = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            wr_en            = 1'b1;
            track_ctl.update = 1'b1;
            state_in         = req_ff.last_board ? ST_REPORT : ST_IDLE;
         end
         ST_REPORT: begin
            track_ctl.report = 1'b1;
            clear_go         = 1'b1;
            state_in         = ST_CLEAR;
         end
         ST_CLEAR: begin
            if (clear_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   mshct_hash #(
      .MAX_INDEX_BITS (MAX_INDEX_BITS)
   ) u_hash (
      .clock      (clock),
      .board      (req_ff.board_word),
      .multiplier (csr_multiplier_ff),
      .eff_bits   (eff_bits),
      .index      (hash_index)
   );

   mshct_table #(
      .MAX_INDEX_BITS (MAX_INDEX_BITS)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .clear_go     (clear_go),
      .rd_en        (rd_en),
      .rd_addr      (hash_index),
      .rd_data      (rd_data),
      .wr_en        (wr_en),
      .wr_addr      (index_ff),
      .wr_data      (wr_data),
      .clear_active (clear_active),
      .clear_last   (clear_last)
   );

   mshct_track u_track (
      .clock      (clock),
      .reset      (reset),
      .ctl        (track_ctl),
      .multiplier (csr_multiplier_ff),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

   `MSHCT_ASSERT(a_rsp_after_report, clock, reset, rsp_valid |-> $past(state_ff == ST_REPORT))
   `MSHCT_ASSERT(a_idle_not_sweeping, clock, reset, !busy |-> !clear_active)
   `MSHCT_ASSERT(a_accept_to_mul, clock, reset, accept |=> (state_ff == ST_MUL))
   `MSHCT_ASSERT(a_write_after_read, clock, reset, wr_en |-> $past(rd_en))
   `MSHCT_ASSERT(a_perfect_matches, clock, reset, rsp_valid |-> (rsp_item.perfect_found == (rsp_item.best_collisions == '0)))

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the multiply-shift hash collision test unit.
`timescale 1ns / 1ps

module tb;
   import mshct_pkg::*;

   localparam int MAX_BITS   = DEF_MAX_INDEX_BITS;
   localparam int TABLE_SIZE = 1 << MAX_BITS;
   localparam int SETTLE     = 12;
   localparam int LIMIT      = 4000000;
   localparam int RANDOM_ITEMS = 600;

   typedef enum logic [1:0] {
      STEP_BOARD,
      STEP_CSR,
      STEP_DRAIN,
      STEP_RATE
   } step_kind_type;

   typedef struct packed {
      step_kind_type        kind;
      req_type              item;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [WORD_W-1:0]    csr_data;
      logic [6:0]           rate;
   } step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_item = '0;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;
   logic                 rsp_valid;
   rsp_type              rsp_item;

   multiply_shift_hash_collision_test_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #6 clock = ~clock;

   step_type          pending_steps[$];
   rsp_type           expected_reports[$];
   int                mismatches = 0;
   int                cycle_count = 0;
   int                quiet_cycles = 0;
   int                idle_pct = 0;
   bit                item_taken = 0;
   int                boards_planned = 0;

   logic [WORD_W-1:0] slot_word [TABLE_SIZE];
   bit                slot_used [TABLE_SIZE];
   logic [COLL_W-1:0] trial_coll;
   logic [FILL_W-1:0] trial_fill;
   logic [WORD_W-1:0] best_mult;
   logic [COLL_W-1:0] best_coll;
   logic [FILL_W-1:0] best_fill;
   logic [WORD_W-1:0] cfg_multiplier;
   logic [IDXCFG_W-1:0] cfg_index_bits;

   function automatic void clear_trial();
      for (int i = 0; i < TABLE_SIZE; i++) begin
         slot_word[i] = '0;
         slot_used[i] = 0;
      end
      trial_coll = '0;
      trial_fill = '0;
   endfunction

   function automatic void clear_best();
      best_mult = '0;
      best_coll = '1;
      best_fill = '0;
   endfunction

   function automatic bit hash_board(input req_type b, output rsp_type r);
      int unsigned       w;
      int unsigned       slot;
      logic [WORD_W-1:0] prod;
      bit                better;
      r = '0;
      w = (cfg_index_bits == 0) ? 1 :
          (cfg_index_bits > MAX_BITS) ? MAX_BITS : cfg_index_bits;
      if (b.restart_search) clear_best();
      prod = b.board_word * cfg_multiplier;
      slot = int'(prod >> (WORD_W - w)) & (TABLE_SIZE - 1);
      if (slot_word[slot] == '0) begin
         slot_word[slot] = b.board_word;
      end else if (slot_word[slot] != b.board_word && trial_coll != '1) begin
         trial_coll++;
      end
      if (!slot_used[slot]) begin
         slot_used[slot] = 1;
         if (trial_fill != '1) trial_fill++;
      end
      if (!b.last_board) return 0;
      better = (trial_coll < best_coll) || (trial_coll == best_coll && trial_fill > best_fill);
      if (better) begin
         best_mult = cfg_multiplier;
         best_coll = trial_coll;
         best_fill = trial_fill;
      end
      r.collision_count = trial_coll;
      r.fill_total      = trial_fill;
      r.new_best        = better;
      r.best_multiplier = best_mult;
      r.best_collisions = best_coll;
      r.best_filled     = best_fill;
      r.perfect_found   = (best_coll == '0);
      clear_trial();
      return 1;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : observe
      rsp_type want;
      rsp_type report;
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
      if (reset) begin
         clear_trial();
         clear_best();
         cfg_multiplier = '0;
         cfg_index_bits = INDEX_BITS_RST;
         quiet_cycles = 0;
         item_taken = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: report expected none got %h", $time, rsp_item);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               check_field("collision_count", 64'(want.collision_count),
                           64'(rsp_item.collision_count));
               check_field("fill_total", 64'(want.fill_total), 64'(rsp_item.fill_total));
               check_field("new_best", 64'(want.new_best), 64'(rsp_item.new_best));
               check_field("best_multiplier", want.best_multiplier, rsp_item.best_multiplier);
               check_field("best_collisions", 64'(want.best_collisions),
                           64'(rsp_item.best_collisions));
               check_field("best_filled", 64'(want.best_filled), 64'(rsp_item.best_filled));
               check_field("perfect_found", 64'(want.perfect_found),
                           64'(rsp_item.perfect_found));
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_MULTIPLIER) cfg_multiplier = csr_wdata;
            else if (csr_index == CSR_INDEX_BITS) cfg_index_bits = csr_wdata[IDXCFG_W-1:0];
         end
         if (start && !busy) begin
            item_taken = 1;
            if (hash_board(req_item, report)) expected_reports.push_back(report);
         end
         if (rsp_valid || (start && !busy)) quiet_cycles = 0;
         else if (quiet_cycles < 1000) quiet_cycles++;
      end
   end

   always @(negedge clock) begin : drive
      logic                 nxt_start;
      req_type              nxt_item;
      logic                 nxt_we;
      logic [CSR_IDX_W-1:0] nxt_idx;
      logic [WORD_W-1:0]    nxt_data;
      bit                   done;
      bit                   settled;
      nxt_start = start;
      nxt_item  = req_item;
      nxt_we    = 1'b0;
      nxt_idx   = csr_index;
      nxt_data  = csr_wdata;
      if (!reset) begin
         if (item_taken) begin
            item_taken = 0;
            nxt_start = 1'b0;
            void'(pending_steps.pop_front());
         end
         settled = (expected_reports.size() == 0) && (quiet_cycles >= SETTLE) && !busy;
         done = 0;
         while (!nxt_start && !done && pending_steps.size() > 0) begin
            case (pending_steps[0].kind)
               STEP_RATE: begin
                  idle_pct = pending_steps[0].rate;
                  void'(pending_steps.pop_front());
               end
               STEP_DRAIN: begin
                  if (settled) void'(pending_steps.pop_front());
                  else done = 1;
               end
               STEP_CSR: begin
                  if (settled) begin
                     nxt_we   = 1'b1;
                     nxt_idx  = pending_steps[0].csr_idx;
                     nxt_data = pending_steps[0].csr_data;
                     void'(pending_steps.pop_front());
                  end
                  done = 1;
               end
               default: begin
                  if ($urandom_range(99) >= idle_pct) begin
                     nxt_start = 1'b1;
                     nxt_item  = pending_steps[0].item;
                  end
                  done = 1;
               end
            endcase
         end
      end
      start     <= nxt_start;
      req_item  <= nxt_item;
      csr_we    <= nxt_we;
      csr_index <= nxt_idx;
      csr_wdata <= nxt_data;
   end

   task automatic plan_board(input logic [63:0] word, input bit last, input bit restart);
      step_type s;
      s = '0;
      s.kind = STEP_BOARD;
      s.item.board_word = word;
      s.item.last_board = last;
      s.item.restart_search = restart;
      pending_steps.push_back(s);
      boards_planned++;
   endtask

   task automatic plan_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      step_type s;
      s = '0;
      s.kind = STEP_CSR;
      s.csr_idx = idx;
      s.csr_data = data;
      pending_steps.push_back(s);
   endtask

   task automatic plan_bits(input logic [IDXCFG_W-1:0] bits);
      plan_csr(CSR_INDEX_BITS, {$urandom, 28'($urandom), bits});
   endtask

   task automatic plan_step(input step_kind_type kind, input int rate);
      step_type s;
      s = '0;
      s.kind = kind;
      s.rate = 7'(rate);
      pending_steps.push_back(s);
   endtask

   function automatic logic [63:0] pick_multiplier();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 64'd1;
         3, 4: return {$urandom, $urandom} | 64'd1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [IDXCFG_W-1:0] pick_bits();
      case ($urandom_range(9))
         0, 1, 2, 3: return IDXCFG_W'($urandom_range(4, 1));
         4, 5, 6: return IDXCFG_W'($urandom_range(12, 5));
         default: return IDXCFG_W'($urandom_range(15, 0));
      endcase
   endfunction

   task automatic plan_random_trial();
      logic [63:0] seen[$];
      logic [63:0] word;
      int          len;
      int          pick;
      pick = $urandom_range(99);
      len = (pick < 80) ? $urandom_range(8, 1) :
            (pick < 95) ? $urandom_range(24, 9) : $urandom_range(60, 25);
      if ($urandom_range(9) < 7) plan_csr(CSR_MULTIPLIER, pick_multiplier());
      if ($urandom_range(9) < 4) plan_bits(pick_bits());
      for (int i = 0; i < len; i++) begin
         if (i > 0 && $urandom_range(99) < 5) begin
            if ($urandom_range(1)) plan_bits(pick_bits());
            else plan_csr(CSR_MULTIPLIER, pick_multiplier());
         end
         case ($urandom_range(19))
            0, 1: word = '0;
            2, 3: word = 64'd1 << $urandom_range(63);
            4, 5, 6: word = 64'($urandom_range(255));
            7, 8, 9: word = (seen.size() > 0) ? seen[$urandom_range(seen.size() - 1)] :
                                                {$urandom, $urandom};
            default: word = {$urandom, $urandom};
         endcase
         seen.push_back(word);
         plan_board(word, i == len - 1,
                    (i == 0) ? ($urandom_range(99) < 30) : ($urandom_range(99) < 5));
      end
   endtask

   initial begin
      plan_step(STEP_RATE, 8);

      plan_csr(CSR_MULTIPLIER, 64'h9E37_79B9_7F4A_7C15);
      plan_csr(CSR_INDEX_BITS, 64'd12);
      plan_board(64'd0, 0, 1);
      plan_board('1, 0, 0);
      plan_board('1, 0, 0);
      plan_board(64'h8000_0000_0000_0001, 1, 0);

      plan_csr(CSR_INDEX_BITS, 64'd0);
      plan_csr(CSR_MULTIPLIER, '1);
      plan_board(64'd1, 0, 0);
      plan_board(64'd2, 0, 0);
      plan_board(64'd3, 0, 0);
      plan_board(64'h5555_5555_5555_5555, 1, 0);

      plan_csr(CSR_INDEX_BITS, 64'hFFFF_FFFF_FFFF_FFFF);
      plan_csr(CSR_MULTIPLIER, 64'd0);
      plan_board(64'd5, 0, 0);
      plan_board(64'd5, 0, 0);
      plan_board(64'd0, 0, 0);
      plan_board(64'd7, 1, 0);

      plan_csr(CSR_MULTIPLIER, 64'h0123_4567_89AB_CDEF);
      plan_csr(CSR_INDEX_BITS, 64'd1);
      plan_board(64'hAAAA_AAAA_AAAA_AAAA, 0, 0);
      plan_csr(CSR_INDEX_BITS, 64'd12);
      plan_board(64'h1234_5678_9ABC_DEF0, 0, 1);
      plan_board(64'hFEDC_BA98_7654_3210, 1, 0);

      plan_csr(CSR_MULTIPLIER, 64'd1);
      plan_board(64'hFFF0_0000_0000_0000, 1, 1);
      plan_board(64'd0, 1, 0);

      boards_planned = 0;
      while (boards_planned < RANDOM_ITEMS / 2) plan_random_trial();
      plan_step(STEP_DRAIN, 0);
      plan_step(STEP_RATE, 55);
      while (boards_planned < RANDOM_ITEMS) plan_random_trial();

      plan_step(STEP_DRAIN, 0);
      plan_step(STEP_RATE, 0);
      plan_csr(CSR_MULTIPLIER, 64'd1);
      plan_csr(CSR_INDEX_BITS, 64'd12);
      for (int t = 0; t < 6; t++) plan_random_trial();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_steps.size() != 0 || start || expected_reports.size() != 0 ||
             quiet_cycles < SETTLE)
         @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
